[src/sgb_pkg.sv]
// Shared constants, codes and helpers for the separable Gaussian blur block.
`default_nettype none
package sgb_pkg;

  localparam int DEF_MAX_PIXELS = 4096;
  localparam int DEF_MAX_WIDTH  = 128;
  localparam int TAPS           = 7;
  localparam int HALF_TAPS      = TAPS / 2;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;
  localparam int ACC_W = 14;   // 255 * 64 fits
  localparam int DVS_W = 7;    // tap sum up to 64
  localparam int WGT_W = 5;
  localparam int DCNT_W = 4;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_BLUR  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] REG_WIDTH      = 2'd0;
  localparam logic [1:0] REG_HEIGHT     = 2'd1;
  localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

  localparam logic [7:0] RST_WIDTH      = 8'd64;
  localparam logic [7:0] RST_HEIGHT     = 8'd64;
  localparam logic [8:0] RST_BRIGHTNESS = 9'd0;

  // binomial taps 1 6 15 20 15 6 1
  function automatic logic [WGT_W-1:0] tap_weight(input logic [2:0] k);
    logic [WGT_W-1:0] w;
    begin
      case (k)
        3'd0, 3'd6: w = 5'd1;
        3'd1, 3'd5: w = 5'd6;
        3'd2, 3'd4: w = 5'd15;
        3'd3:       w = 5'd20;
        default:    w = 5'd0;
      endcase
      return w;
    end
  endfunction

endpackage
`default_nettype wire

[src/sgb_if.sv]
// Valid/ready channel interfaces for command beats and result beats.
`default_nettype none
interface sgb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] pixel_addr;
  logic [7:0]  red_in;
  logic [7:0]  green_in;
  logic [7:0]  blue_in;
  modport source (output valid, func, pixel_addr, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, func, pixel_addr, red_in, green_in, blue_in, output ready);
endinterface

interface sgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       done_res;
  modport source (output valid, red_out, green_out, blue_out, done_res, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, done_res, output ready);
endinterface
`default_nettype wire

[src/sgb_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/separable_gaussian_blur.sv]
// Separable 7-tap blur over a pixel store: a write beat completes in the idle state, a read
// beat takes one memory read. A blur beat first bounds the row count, one row at a time, then
// runs two passes, each pixel going through a start step, 7 tap reads through one memory read
// port, a drain step, a 14-step shared divider and a write back. The stores are not cleared
// after reset; reading a pixel before it was written returns whatever the memory holds.
`default_nettype none
module separable_gaussian_blur
  import sgb_pkg::*;
#(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sgb_in_if.sink           in_ch,
  sgb_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int AW  = $clog2(MAX_PIXELS);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int TCW = ((WW > 8) ? WW : 8) + 2;
  localparam int TAW = ((AW > WW + 3) ? AW : WW + 3) + 2;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RD    = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_TAP   = 3'd4;
  localparam logic [2:0] ST_DRAIN = 3'd5;
  localparam logic [2:0] ST_DIV   = 3'd6;
  localparam logic [2:0] ST_WR    = 3'd7;

  // configuration
  logic [7:0] width_r, height_r;
  logic [8:0] bright_r;
  logic       cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
      bright_r <= RST_BRIGHTNESS;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_WIDTH:      width_r  <= cfg_pwdata[7:0];
        REG_HEIGHT:     height_r <= cfg_pwdata[7:0];
        REG_BRIGHTNESS: bright_r <= cfg_pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_WIDTH:      cfg_prdata = {24'd0, width_r};
      REG_HEIGHT:     cfg_prdata = {24'd0, height_r};
      REG_BRIGHTNESS: cfg_prdata = {23'd0, bright_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  logic [WW-1:0] w_eff;
  assign w_eff = (32'(width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_r);

  // state
  logic [2:0]        st_r, st_nxt;
  logic              pass_r, pass_nxt;
  logic [7:0]        rows_r, rows_nxt;
  logic [AW:0]       total_r, total_nxt;
  logic [WW-1:0]     col_r, col_nxt;
  logic [7:0]        row_r, row_nxt;
  logic [AW-1:0]     pix_r, pix_nxt;
  logic [2:0]        k_r, k_nxt;
  logic signed [TCW-1:0] tap_c_r, tap_c_nxt;
  logic signed [TAW-1:0] tap_addr_r, tap_addr_nxt;
  logic              vld_d_r;
  logic [2:0]        k_d_r;
  logic [ACC_W-1:0]  acc_r [3], acc_nxt [3];
  logic [DVS_W-1:0]  rem_r [3], rem_nxt [3];
  logic [DVS_W-1:0]  dvs_r, dvs_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]  out_pix_r, out_pix_nxt;
  logic              out_done_r, out_done_nxt;

  // memories
  logic              img_we, scr_we;
  logic [AW-1:0]     img_waddr, img_raddr;
  logic [PIX_W-1:0]  img_wdata, img_rdata, scr_wdata, scr_rdata;

  sgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_img (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(img_wdata),
    .raddr(img_raddr), .rdata(img_rdata)
  );
  sgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_PIXELS)) u_scr (
    .clk(clk), .we(scr_we), .waddr(pix_r), .wdata(scr_wdata),
    .raddr(tap_addr_r[AW-1:0]), .rdata(scr_rdata)
  );

  logic in_acc, addr_ok;
  assign in_ch.ready = (st_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign addr_ok = 32'(in_ch.pixel_addr) < MAX_PIXELS;

  // tap window
  logic signed [TCW-1:0] lim, coord;
  logic signed [TAW-1:0] step;
  logic tap_ok;
  assign lim    = pass_r ? TCW'(rows_r) : TCW'(w_eff);
  assign coord  = pass_r ? TCW'(row_r) : TCW'(col_r);
  assign step   = pass_r ? TAW'(w_eff) : TAW'(1);
  assign tap_ok = (tap_c_r >= 0) && (tap_c_r < lim);

  // accumulate the tap returned by the read of the previous cycle
  logic [PIX_W-1:0] tap_pix;
  logic [WGT_W-1:0] wgt;
  assign tap_pix = pass_r ? scr_rdata : img_rdata;
  assign wgt     = tap_weight(k_d_r);

  // result of the divider, brightness applied on the vertical pass
  logic [PIX_W-1:0] res_pix;
  always_comb begin
    logic signed [10:0] s;
    for (int c = 0; c < 3; c++) begin
      s = $signed({3'b0, acc_r[c][CH_W-1:0]}) + 11'($signed(bright_r));
      if (!pass_r)        res_pix[(2-c)*CH_W +: CH_W] = acc_r[c][CH_W-1:0];
      else if (s < 0)     res_pix[(2-c)*CH_W +: CH_W] = 8'd0;
      else if (s > 255)   res_pix[(2-c)*CH_W +: CH_W] = 8'd255;
      else                res_pix[(2-c)*CH_W +: CH_W] = s[CH_W-1:0];
    end
  end

  always_comb begin
    logic [DVS_W:0] t;
    st_nxt = st_r; pass_nxt = pass_r; rows_nxt = rows_r; total_nxt = total_r;
    col_nxt = col_r; row_nxt = row_r; pix_nxt = pix_r; k_nxt = k_r;
    tap_c_nxt = tap_c_r; tap_addr_nxt = tap_addr_r;
    dvs_nxt = dvs_r; dcnt_nxt = dcnt_r;
    acc_nxt = acc_r; rem_nxt = rem_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_pix_nxt = out_pix_r; out_done_nxt = out_done_r;
    img_we = 1'b0; img_waddr = pix_r; img_wdata = res_pix;
    img_raddr = tap_addr_r[AW-1:0];
    scr_we = 1'b0; scr_wdata = res_pix;

    if (vld_d_r) begin
      for (int c = 0; c < 3; c++)
        acc_nxt[c] = acc_r[c] + ACC_W'(wgt) * ACC_W'(tap_pix[(2-c)*CH_W +: CH_W]);
      dvs_nxt = dvs_r + DVS_W'(wgt);
    end

    unique case (st_r)
      ST_IDLE: begin
        img_raddr = AW'(in_ch.pixel_addr);
        if (in_acc) begin
          out_pix_nxt  = '0;
          out_done_nxt = 1'b1;
          unique case (in_ch.func)
            FUNC_WRITE: begin
              img_we        = addr_ok;
              img_waddr     = AW'(in_ch.pixel_addr);
              img_wdata     = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
              out_valid_nxt = 1'b1;
            end
            FUNC_READ: begin
              if (addr_ok) st_nxt = ST_RD;
              else out_valid_nxt = 1'b1;
            end
            FUNC_BLUR: begin
              st_nxt = ST_PREP; rows_nxt = '0; total_nxt = '0;
              pass_nxt = 1'b0; col_nxt = '0; row_nxt = '0; pix_nxt = '0;
            end
            default: begin
              out_done_nxt  = 1'b0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RD: begin
        out_pix_nxt = img_rdata; out_valid_nxt = 1'b1; st_nxt = ST_IDLE;
      end
      ST_PREP: begin
        // rows = min(height, MAX_PIXELS / width), counted one row a cycle
        if (w_eff != '0 && rows_r < height_r &&
            32'(total_r) + 32'(w_eff) <= MAX_PIXELS) begin
          rows_nxt  = rows_r + 8'd1;
          total_nxt = total_r + (AW+1)'(w_eff);
        end else if (rows_r == '0) begin
          out_valid_nxt = 1'b1; st_nxt = ST_IDLE;
        end else begin
          st_nxt = ST_START;
        end
      end
      ST_START: begin
        for (int c = 0; c < 3; c++) begin
          acc_nxt[c] = '0; rem_nxt[c] = '0;
        end
        dvs_nxt = '0; dcnt_nxt = '0; k_nxt = '0;
        tap_c_nxt    = coord - TCW'(HALF_TAPS);
        tap_addr_nxt = $signed(TAW'(pix_r)) - TAW'(3) * step;
        st_nxt = ST_TAP;
      end
      ST_TAP: begin
        tap_c_nxt    = tap_c_r + TCW'(1);
        tap_addr_nxt = tap_addr_r + step;
        k_nxt = k_r + 3'd1;
        if (k_r == 3'(TAPS - 1)) st_nxt = ST_DRAIN;
      end
      ST_DRAIN: st_nxt = ST_DIV;
      ST_DIV: begin
        // restoring divide, one quotient bit per cycle, all channels at once
        for (int c = 0; c < 3; c++) begin
          t = {rem_r[c], acc_r[c][ACC_W-1]};
          if (t >= {1'b0, dvs_r}) begin
            rem_nxt[c] = DVS_W'(t - {1'b0, dvs_r});
            acc_nxt[c] = {acc_r[c][ACC_W-2:0], 1'b1};
          end else begin
            rem_nxt[c] = DVS_W'(t);
            acc_nxt[c] = {acc_r[c][ACC_W-2:0], 1'b0};
          end
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DCNT_W'(ACC_W - 1)) st_nxt = ST_WR;
      end
      ST_WR: begin
        img_we = pass_r;
        scr_we = !pass_r;
        st_nxt = ST_START;
        if (col_r == w_eff - 1'b1 && row_r == rows_r - 8'd1) begin
          col_nxt = '0; row_nxt = '0; pix_nxt = '0;
          if (!pass_r) pass_nxt = 1'b1;
          else begin
            out_valid_nxt = 1'b1; st_nxt = ST_IDLE;
          end
        end else begin
          pix_nxt = pix_r + 1'b1;
          if (col_r == w_eff - 1'b1) begin
            col_nxt = '0; row_nxt = row_r + 8'd1;
          end else col_nxt = col_r + 1'b1;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      vld_d_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid_r <= out_valid_nxt;
      vld_d_r <= (st_r == ST_TAP) && tap_ok;
    end
  end

  always_ff @(posedge clk) begin
    pass_r <= pass_nxt; rows_r <= rows_nxt; total_r <= total_nxt;
    col_r <= col_nxt; row_r <= row_nxt; pix_r <= pix_nxt; k_r <= k_nxt;
    tap_c_r <= tap_c_nxt; tap_addr_r <= tap_addr_nxt;
    k_d_r <= k_r;
    acc_r <= acc_nxt; rem_r <= rem_nxt;
    dvs_r <= dvs_nxt; dcnt_r <= dcnt_nxt;
    out_pix_r <= out_pix_nxt; out_done_r <= out_done_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.red_out   = out_pix_r[23:16];
  assign out_ch.green_out = out_pix_r[15:8];
  assign out_ch.blue_out  = out_pix_r[7:0];
  assign out_ch.done_res  = out_done_r;

  // center tap is always inside the image, so the divisor is never zero
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DIV) |-> (dvs_r != '0)) else $error("zero tap sum");
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WR) |-> (row_r < rows_r)) else $error("row beyond bound");
  a_blur_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_BLUR) |=> (st_r == ST_PREP))
    else $error("blur beat did not start");
  a_no_result_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r) else $error("result lost");
endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the separable Gaussian blur block: directed table, then random traffic.
module tb_top;
  import sgb_pkg::*;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] addr;
    logic [7:0]  r, g, b;
  } cmd_t;

  typedef struct packed {
    logic [7:0] r, g, b;
    logic       done;
  } pix_res_t;

  typedef struct {
    cmd_t     cmd;
    bit       fixed;   // expected value typed in below
    pix_res_t res;
  } row_t;

  localparam int WATCHDOG = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sgb_in_if  in_ch ();
  sgb_out_if out_ch ();

  separable_gaussian_blur u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [23:0] img_mem [DEF_MAX_PIXELS];
  logic [23:0] tmp_mem [DEF_MAX_PIXELS];
  bit          written [DEF_MAX_PIXELS];
  int          cur_w = 64, cur_h = 64, cur_ofs = 0;

  pix_res_t pending_px[$];
  int  n_err = 0;
  int  send_idle = 0, recv_idle = 0;
  int  stall_cnt = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = '0;
    in_ch.pixel_addr = '0;
    in_ch.red_in = '0;
    in_ch.green_in = '0;
    in_ch.blue_in = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report(input string what, input int got, input int want);
    n_err++;
    $display("mismatch %s: got %0d want %0d (%0t)", what, got, want, $realtime);
  endtask

  function automatic int wt(input int k);
    int t[7] = '{1, 6, 15, 20, 15, 6, 1};
    return t[k];
  endfunction

  function automatic int clip8(input int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic void blur_image();
    int w, h, s[3], dv, c, px;
    w = cur_w;
    h = cur_h;
    if (w == 0 || h == 0) return;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    if (h > DEF_MAX_PIXELS / w) h = DEF_MAX_PIXELS / w;
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++) begin
        s = '{0, 0, 0};
        dv = 0;
        for (int k = 0; k < TAPS; k++) begin
          c = i - HALF_TAPS + k;
          if (c >= 0 && c < w) begin
            px = img_mem[j * w + c];
            for (int ch = 0; ch < 3; ch++) s[ch] += wt(k) * ((px >> (16 - 8 * ch)) & 255);
            dv += wt(k);
          end
        end
        tmp_mem[j * w + i] = {8'(clip8(s[0] / dv)), 8'(clip8(s[1] / dv)), 8'(clip8(s[2] / dv))};
      end
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++) begin
        s = '{0, 0, 0};
        dv = 0;
        for (int k = 0; k < TAPS; k++) begin
          c = j - HALF_TAPS + k;
          if (c >= 0 && c < h) begin
            px = tmp_mem[c * w + i];
            for (int ch = 0; ch < 3; ch++) s[ch] += wt(k) * ((px >> (16 - 8 * ch)) & 255);
            dv += wt(k);
          end
        end
        img_mem[j * w + i] = {8'(clip8(s[0] / dv + cur_ofs)), 8'(clip8(s[1] / dv + cur_ofs)),
                              8'(clip8(s[2] / dv + cur_ofs))};
      end
  endfunction

  function automatic pix_res_t predict_pixel(input cmd_t c);
    pix_res_t o;
    o = '{default: 0};
    o.done = 1'b1;
    case (c.func)
      FUNC_WRITE: begin
        img_mem[c.addr] = {c.r, c.g, c.b};
        written[c.addr] = 1'b1;
      end
      FUNC_BLUR: blur_image();
      FUNC_READ: {o.r, o.g, o.b} = img_mem[c.addr];
      default: o.done = 1'b0;
    endcase
    return o;
  endfunction

  // blur only valid when every pixel it touches was written
  function automatic bit blur_safe();
    int w, h;
    w = cur_w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : cur_w;
    if (w == 0 || cur_h == 0) return 1;
    h = cur_h > DEF_MAX_PIXELS / w ? DEF_MAX_PIXELS / w : cur_h;
    for (int p = 0; p < w * h; p++) if (!written[p]) return 0;
    return 1;
  endfunction

  task automatic cfg_write(input logic [1:0] idx, input int val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(idx) << 2;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_WIDTH:  cur_w = val & 255;
      REG_HEIGHT: cur_h = val & 255;
      default:    cur_ofs = (val & 256) ? (val & 511) - 512 : (val & 511);
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // valid stays up after an accepted beat until the next one, an idle cycle or a drain
  task automatic send_cmd(input cmd_t c, input bit fixed, input pix_res_t want);
    pix_res_t p;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.func, in_ch.pixel_addr, in_ch.red_in, in_ch.green_in, in_ch.blue_in} <= c;
    do @(posedge clk); while (!in_ch.ready);
    p = predict_pixel(c);
    if (fixed && p != want) report("table row vs predictor", p, want);
    pending_px.push_back(p);
  endtask

  function automatic cmd_t mk(input logic [1:0] f, input int a, input int r = 0,
                              input int g = 0, input int b = 0);
    return '{f, 12'(a), 8'(r), 8'(g), 8'(b)};
  endfunction

  // receive side
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_px.size() == 0) begin
          report("unexpected beat", out_ch.red_out, 0);
        end else begin
          pix_res_t e;
          e = pending_px.pop_front();
          if (out_ch.red_out !== e.r) report("red_out", out_ch.red_out, e.r);
          if (out_ch.green_out !== e.g) report("green_out", out_ch.green_out, e.g);
          if (out_ch.blue_out !== e.b) report("blue_out", out_ch.blue_out, e.b);
          if (out_ch.done_res !== e.done) report("done_res", out_ch.done_res, e.done);
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    pix_res_t z, dn;
    int w, h, a, phase;
    z = '{default: 0};
    dn = '{default: 0};
    dn.done = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 8x4 image, extremes, unknown command, blur, brightness extremes
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, 4);
    for (int p = 0; p < 32; p++) begin
      cmd_t c;
      c = mk(FUNC_WRITE, p, (p & 1) ? 255 : 0, p * 8, (p & 2) ? 255 : 0);
      rows.push_back('{c, 1'b1, dn});
    end
    rows.push_back('{mk(FUNC_WRITE, 4095, 255, 255, 255), 1'b1, dn});
    rows.push_back('{mk(FUNC_READ, 4095), 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}});
    rows.push_back('{mk(FUNC_READ, 1), 1'b1, '{8'd255, 8'd8, 8'd0, 1'b1}});
    rows.push_back('{mk(2'd3, 12'hAAA, 255, 255, 255), 1'b1, z});
    rows.push_back('{mk(FUNC_BLUR, 0), 1'b1, dn});
    rows.push_back('{mk(FUNC_READ, 0), 1'b0, z});
    rows.push_back('{mk(FUNC_READ, 31), 1'b0, z});
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].fixed, rows[i].res);
    drain();
    cfg_write(REG_BRIGHTNESS, 255);
    send_cmd(mk(FUNC_BLUR, 0), 1'b1, dn);
    send_cmd(mk(FUNC_READ, 5), 1'b1, '{8'd255, 8'd255, 8'd255, 1'b1});
    drain();
    cfg_write(REG_BRIGHTNESS, 9'h100);   // -256 clamps to black
    send_cmd(mk(FUNC_BLUR, 0), 1'b1, dn);
    send_cmd(mk(FUNC_READ, 17), 1'b1, '{8'd0, 8'd0, 8'd0, 1'b1});
    drain();
    cfg_write(REG_WIDTH, 0);             // zero size blur does nothing
    send_cmd(mk(FUNC_BLUR, 0), 1'b1, dn);
    drain();

    // random phases: small images, fill, blur, reads, noise
    for (phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 33 : (phase == 1 ? 47 : 0);
      recv_idle = phase == 0 ? 47 : (phase == 1 ? 33 : 0);
      for (int blk = 0; blk < 2; blk++) begin
        drain();
        case ($urandom_range(3))
          0: begin w = 1; h = 1; end
          1: begin w = 128; h = 1; end
          2: begin w = 1; h = 12; end
          default: begin w = $urandom_range(2, 9); h = $urandom_range(1, 6); end
        endcase
        cfg_write(REG_WIDTH, w);
        cfg_write(REG_HEIGHT, h);
        cfg_write(REG_BRIGHTNESS, $urandom_range(511));
        for (int p = 0; p < w * h; p++)
          send_cmd(mk(FUNC_WRITE, p, $urandom_range(255), $urandom_range(255),
                      $urandom_range(255)), 1'b0, z);
        for (int n = 0; n < 30; n++) begin
          case ($urandom_range(9))
            0: if (blur_safe()) send_cmd(mk(FUNC_BLUR, $urandom_range(4095)), 1'b0, z);
            1: send_cmd(mk(2'd3, $urandom_range(4095), $urandom_range(255),
                           $urandom_range(255), $urandom_range(255)), 1'b0, z);
            2, 3: send_cmd(mk(FUNC_WRITE, $urandom_range(4095), $urandom_range(255),
                              $urandom_range(255), $urandom_range(255)), 1'b0, z);
            default: begin
              a = $urandom_range(w * h - 1);
              if ($urandom_range(3) == 0) a = $urandom_range(4095);
              if (written[a]) send_cmd(mk(FUNC_READ, a), 1'b0, z);
            end
          endcase
        end
        if (blur_safe()) send_cmd(mk(FUNC_BLUR, 0), 1'b0, z);
        for (int p = 0; p < w * h; p++) send_cmd(mk(FUNC_READ, p), 1'b0, z);
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
